FILE: src/trie_word_insert_search_assert.svh
// Assertion macros shared by the trie word insert/search modules.
`ifndef TRIE_WORD_INSERT_SEARCH_ASSERT_SVH
`define TRIE_WORD_INSERT_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TWIS_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("trie assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TWIS_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("trie assertion failed");
`else
`define TWIS_ASSERT_IMP(label, pre, post)
`define TWIS_ASSERT_NXT(label, pre, post)
`endif
`endif

FILE: src/twis_pkg.sv
// Shared types and constants of the trie word insert/search block.
package twis_pkg;

	localparam int NODE_COUNT_DEF    = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int LETTER_W          = 5;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // zero one link entry and, while the sweep is below NODE_COUNT, one mark entry; advance sweep
		logic take;       // capture the item and read its child link
		logic step;       // resolve the link read, allocate or descend
		logic mark_rd;    // read the word-end mark of the cursor node
		logic mark_take;  // capture the search answer, close the word
		logic load_out;   // move the result into the output register
	} twis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done; // sweep is on its final entry
		logic last;       // item in work is the final letter of its word
		logic search;     // current word is a search
	} twis_sts_t;

endpackage

FILE: src/twis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/twis_dp.sv
// Datapath of the trie: link and mark memories, cursor, allocator, result registers.
`include "trie_word_insert_search_assert.svh"

module twis_dp import twis_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                kind,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last,
	input  twis_cmd_t           cmd,
	output twis_sts_t           sts,
	output logic                found,
	output logic                status
);

	localparam int NW         = $clog2(NODE_COUNT);
	localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
	localparam int SW         = $clog2(LINK_DEPTH);

	logic [SW-1:0] clr_cnt_q;
	logic [NW:0]   next_free_q;
	logic [NW-1:0] cursor_q;
	logic          kind_q;
	logic          failed_q;
	logic          mid_word_q;
	logic          last_q;
	logic          in_range_q;
	logic [SW-1:0] slot_q;
	logic          found_q;
	logic          status_q;

	logic [SW-1:0] slot_d;
	logic          in_range_d;
	logic [NW-1:0] link_rd;
	logic          mark_rd;
	logic          pool_full;
	logic          child_absent;
	logic          fail_now;
	logic          alloc;
	logic          step_failed;
	logic [NW-1:0] step_cursor;
	logic          insert_end;

	logic          link_we;
	logic [SW-1:0] link_waddr;
	logic [NW-1:0] link_wdata;
	logic          mark_we;
	logic [NW-1:0] mark_waddr;
	logic          mark_wdata;

	// Slot of the child link for this letter under the cursor node.
	assign slot_d     = SW'(SW'(cursor_q) * SW'(ALPHABET_SIZE)) + SW'(letter);
	assign in_range_d = 32'(letter) < ALPHABET_SIZE;

	assign pool_full    = next_free_q == (NW+1)'(NODE_COUNT);
	assign child_absent = link_rd == '0;
	assign fail_now     = !failed_q && (!in_range_q ||
		(child_absent && (kind_q == KIND_SEARCH || pool_full)));
	assign alloc        = !failed_q && in_range_q && child_absent &&
		kind_q == KIND_INSERT && !pool_full;
	assign step_failed  = failed_q || fail_now;
	assign step_cursor  = step_failed ? cursor_q :
		(child_absent ? next_free_q[NW-1:0] : link_rd);
	assign insert_end   = cmd.step && last_q && kind_q == KIND_INSERT;

	// Link memory: sweep writes zero, allocation writes the new node.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = next_free_q[NW-1:0];
		if (cmd.clear) begin
			link_we    = 1'b1;
			link_waddr = clr_cnt_q;
			link_wdata = '0;
		end else if (cmd.step && alloc) begin
			link_we = 1'b1;
		end
	end

	// Mark memory: sweep clears, a completed insert sets the mark.
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = step_cursor;
		mark_wdata = 1'b1;
		if (cmd.clear) begin
			mark_we    = 32'(clr_cnt_q) < NODE_COUNT;
			mark_waddr = clr_cnt_q[NW-1:0];
			mark_wdata = 1'b0;
		end else if (insert_end && !step_failed) begin
			mark_we = 1'b1;
		end
	end

	twis_ram #(
		.WIDTH (NW),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.take),
		.raddr (slot_d),
		.rdata (link_rd)
	);

	twis_ram #(
		.WIDTH (1),
		.DEPTH (NODE_COUNT)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (cmd.mark_rd),
		.raddr (cursor_q),
		.rdata (mark_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			next_free_q <= (NW+1)'(1);
			cursor_q    <= '0;
			kind_q      <= KIND_INSERT;
			failed_q    <= 1'b0;
			mid_word_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + SW'(1);
			end
			if (cmd.take && !mid_word_q) begin
				kind_q     <= kind;
				mid_word_q <= 1'b1;
			end
			if (cmd.step) begin
				if (alloc) begin
					next_free_q <= next_free_q + (NW+1)'(1);
				end
				if (insert_end) begin
					cursor_q   <= '0;
					failed_q   <= 1'b0;
					mid_word_q <= 1'b0;
				end else begin
					cursor_q <= step_cursor;
					failed_q <= step_failed;
				end
			end
			if (cmd.mark_take) begin
				cursor_q   <= '0;
				failed_q   <= 1'b0;
				mid_word_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			slot_q     <= slot_d;
			in_range_q <= in_range_d;
			last_q     <= last;
		end
		if (insert_end) begin
			found_q  <= 1'b0;
			status_q <= step_failed;
		end
		if (cmd.mark_take) begin
			found_q  <= !failed_q && mark_rd;
			status_q <= 1'b0;
		end
		if (cmd.load_out) begin
			found  <= found_q;
			status <= status_q;
		end
	end

	assign sts.clear_done = clr_cnt_q == SW'(LINK_DEPTH - 1);
	assign sts.last       = last_q;
	assign sts.search     = kind_q == KIND_SEARCH;

	`TWIS_ASSERT_IMP(a_pool_bound, 1'b1, next_free_q <= (NW+1)'(NODE_COUNT))
	`TWIS_ASSERT_IMP(a_cursor_allocated, 1'b1, (NW+1)'(cursor_q) < next_free_q)
	`TWIS_ASSERT_IMP(a_word_starts_at_root, cmd.take && !mid_word_q, cursor_q == '0 && !failed_q)

endmodule

FILE: src/twis_ctrl.sv
// Controller state machine of the trie: sweep, letter walk, mark access, result handoff.
`include "trie_word_insert_search_assert.svh"

module twis_ctrl import twis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  twis_sts_t sts,
	output twis_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_MREAD = 3'd3;
	localparam logic [2:0] ST_MTAKE = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (sts.search) begin
					state_d = ST_MREAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MREAD: begin
				cmd.mark_rd = 1'b1;
				state_d     = ST_MTAKE;
			end
			ST_MTAKE: begin
				cmd.mark_take = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	`TWIS_ASSERT_NXT(a_accept_to_step, in_valid && in_ready, state_q == ST_STEP)
	`TWIS_ASSERT_NXT(a_load_shows_result, cmd.load_out, out_valid_q)
	`TWIS_ASSERT_IMP(a_no_result_in_sweep, state_q == ST_CLEAR, !out_valid_q)

endmodule

FILE: src/trie_word_insert_search.sv
// Top level of the trie word insert/search block.
//
// A trie of words over ALPHABET_SIZE letters, kept in a pool of NODE_COUNT
// nodes with node 0 as the root. Words arrive one letter per input item, the
// final letter flagged by last; kind (0 insert, 1 search) is taken from the
// first letter of each word and holds for the whole word. Exactly one result
// item leaves per word, on its final letter: a search reports found = 1 when
// the word was inserted before; an insert reports status = 1 when it ran out
// of nodes (or met a letter outside the alphabet) and left the word unmarked.
// Nodes taken before such a stop stay in the trie. After reset the block
// sweeps both memories to zero, one link entry per cycle, and takes no item
// until all NODE_COUNT * ALPHABET_SIZE link entries (26624 at the defaults)
// are swept. A non-final letter then passes IDLE and STEP: the child link
// read is registered, and the next letter needs the node it returns. A final
// letter goes on to FIN for an insert and through MREAD and MTAKE for a
// search, whose word-end mark is read in a second memory access; a result
// then waits in the output register until taken, and the walk of the
// following word starts only once that register has room for its result.
module trie_word_insert_search import twis_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input items: one letter each
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last,
	// result items: one per word
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic                status
);

	twis_cmd_t cmd;
	twis_sts_t sts;

	// Sequence the sweep, the per-letter walk and the result handoff.
	twis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the node pool, the cursor and the result register.
	twis_dp #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.kind   (kind),
		.letter (letter),
		.last   (last),
		.cmd    (cmd),
		.sts    (sts),
		.found  (found),
		.status (status)
	);

endmodule

FILE: verif/trie_word_checker.sv
// Checker for the trie word insert/search block: predicts each word's answer and compares.
`timescale 1ns / 100ps
module trie_word_checker import twis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                kind,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                found,
	input  logic                status,
	output int                  failures,
	output int                  answers_pending
);

	localparam int NODE_W     = $clog2(NODE_COUNT_DEF);
	localparam int LINK_DEPTH = NODE_COUNT_DEF * ALPHABET_SIZE_DEF;

	typedef struct packed {
		logic found;
		logic status;
	} word_answer_t;

	// shadow trie
	bit [NODE_W-1:0] child_link [LINK_DEPTH];
	bit              word_end   [NODE_COUNT_DEF];
	bit [NODE_W:0]   free_node;
	bit [NODE_W-1:0] cursor;
	logic            word_kind;
	bit              walk_failed;
	bit              in_word;

	word_answer_t    answers_due [$];
	int              fail_total = 0;

	// One letter of the walk: descend, allocate on insert, or fail.
	function automatic void descend(input logic [LETTER_W-1:0] ltr);
		int unsigned slot;
		if (walk_failed || ltr >= ALPHABET_SIZE_DEF) begin
			walk_failed = 1'b1;
			return;
		end
		slot = cursor * ALPHABET_SIZE_DEF + ltr;
		if (child_link[slot] == '0) begin
			if (word_kind == KIND_SEARCH || free_node >= NODE_COUNT_DEF) begin
				walk_failed = 1'b1;
				return;
			end
			child_link[slot] = free_node[NODE_W-1:0];
			free_node = free_node + 1'b1;
		end
		cursor = child_link[slot];
	endfunction

	task automatic report_failure(input string msg);
		fail_total++;
		if (fail_total <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_answer_t ans;
		word_answer_t due;
		if (!arst_n) begin
			for (int i = 0; i < LINK_DEPTH; i++)
				child_link[i] = '0;
			for (int i = 0; i < NODE_COUNT_DEF; i++)
				word_end[i] = 1'b0;
			free_node       = 1;
			cursor          = '0;
			word_kind       = KIND_INSERT;
			walk_failed     = 1'b0;
			in_word         = 1'b0;
			answers_due.delete();
			answers_pending <= 0;
			failures        <= fail_total;
		end else begin
			if (in_valid && in_ready) begin
				// kind counts only on the first letter of a word
				if (!in_word) begin
					word_kind   = kind;
					cursor      = '0;
					walk_failed = 1'b0;
					in_word     = 1'b1;
				end
				descend(letter);
				if (last) begin
					ans = '0;
					if (word_kind == KIND_INSERT) begin
						if (walk_failed)
							ans.status = 1'b1;
						else
							word_end[cursor] = 1'b1;
					end else if (!walk_failed) begin
						ans.found = word_end[cursor];
					end
					answers_due.push_back(ans);
					in_word = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_failure($sformatf("answer found=%b status=%b with no word pending",
						found, status));
				end else begin
					due = answers_due.pop_front();
					if (due.found !== found || due.status !== status)
						report_failure($sformatf(
							"answer mismatch: expected found=%b status=%b, got found=%b status=%b",
							due.found, due.status, found, status));
				end
			end
			answers_pending <= answers_due.size();
			failures        <= fail_total;
		end
	end

endmodule

FILE: verif/tb_trie_word_insert_search.sv
// Testbench top of the trie word insert/search block: drives words, takes answers, gives the verdict.
`timescale 1ns / 100ps
module tb_trie_word_insert_search;
	import twis_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;  // clearing sweep alone covers all 26624 link entries
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 400;
	localparam int MAX_WORD        = 24;
	localparam int BANK_W          = 8;       // letters a remembered word can hold
	localparam int BANK_DEPTH      = 64;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                kind;
	logic [LETTER_W-1:0] letter;
	logic                last;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic                status;

	int  failures;
	int  answers_pending;
	int  cycles = 0;
	int  items_sent = 0;
	bit  quiet = 1'b0;      // no idling on either side while set
	bit  hold_req = 1'b0;   // ask the receiver for its long hold-off

	// word being sent, and a bank of inserted words to search for again
	logic [LETTER_W-1:0]        word_buf [MAX_WORD];
	logic [BANK_W*LETTER_W-1:0] bank_word [$];
	int                         bank_len [$];

	trie_word_insert_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.letter    (letter),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.status    (status)
	);

	trie_word_checker answer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.letter          (letter),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.status          (status),
		.failures        (failures),
		.answers_pending (answers_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a stuck handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it. Now and then
	// drop valid first, with junk on the payload.
	task automatic send_letter(input logic k, input logic [LETTER_W-1:0] ltr, input logic fin);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 6)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			kind     <= 1'($urandom);
			letter   <= LETTER_W'($urandom);
			last     <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		letter   <= ltr;
		last     <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Send word_buf[0 .. len-1]; kind on the later letters is random since
	// the block must ignore it.
	task automatic send_word(input logic k, input int len);
		for (int i = 0; i < len; i++)
			send_letter(i == 0 ? k : 1'($urandom), word_buf[i], i == len - 1);
	endtask

	// Mostly a narrow alphabet so words share prefixes and searches hit;
	// sometimes the full alphabet, rarely a letter past its end.
	function automatic logic [LETTER_W-1:0] pick_letter();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return LETTER_W'($urandom_range(31, ALPHABET_SIZE_DEF));
		if (roll < 25)
			return LETTER_W'($urandom_range(ALPHABET_SIZE_DEF - 1));
		return LETTER_W'($urandom_range(3));
	endfunction

	// One random word: about half the time a bank word, as is, cut short
	// to a prefix or extended by a letter; otherwise a fresh short word.
	task automatic random_word();
		logic                       k;
		int                         len;
		int                         pick;
		logic [BANK_W*LETTER_W-1:0] w;
		k = 1'($urandom);
		w = '0;
		if (bank_word.size() > 0 && $urandom_range(99) < 50) begin
			pick = $urandom_range(bank_word.size() - 1);
			w    = bank_word[pick];
			len  = bank_len[pick];
			case ($urandom_range(3))
				0: if (len > 1) len--;
				1: if (len < BANK_W) begin
					w[len*LETTER_W +: LETTER_W] = pick_letter();
					len++;
				end
				default: ;
			endcase
		end else begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++)
				w[i*LETTER_W +: LETTER_W] = pick_letter();
			if (k == KIND_INSERT && bank_word.size() < BANK_DEPTH) begin
				bank_word.push_back(w);
				bank_len.push_back(len);
			end
		end
		for (int i = 0; i < len; i++)
			word_buf[i] = w[i*LETTER_W +: LETTER_W];
		send_word(k, len);
	endtask

	// Receiver: take answers, stall now and then, and once hold off for a
	// long stretch so the output register fills and the input backs up.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 6;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int start;
		in_valid <= 1'b0;
		kind     <= KIND_INSERT;
		letter   <= '0;
		last     <= 1'b0;
		arst_n   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words. The block sweeps its memories first; the first
		// item simply waits for in_ready.
		send_letter(KIND_SEARCH, 5'd0, 1'b1);   // search on the empty trie misses
		send_letter(KIND_INSERT, 5'd0, 1'b1);   // insert "a"
		send_letter(KIND_SEARCH, 5'd0, 1'b1);   // and find it
		send_letter(KIND_INSERT, 5'd25, 1'b1);  // highest letter
		// insert "zaz" with search kind on later letters: must stay an insert
		send_letter(KIND_INSERT, 5'd25, 1'b0);
		send_letter(KIND_SEARCH, 5'd0, 1'b0);
		send_letter(KIND_SEARCH, 5'd25, 1'b1);
		// prefix "za" exists as a node but is no word end
		send_letter(KIND_SEARCH, 5'd25, 1'b0);
		send_letter(KIND_SEARCH, 5'd0, 1'b1);
		// search "zaz" with insert kind on later letters
		send_letter(KIND_SEARCH, 5'd25, 1'b0);
		send_letter(KIND_INSERT, 5'd0, 1'b0);
		send_letter(KIND_INSERT, 5'd25, 1'b1);
		// absent child: the search misses
		send_letter(KIND_SEARCH, 5'd0, 1'b0);
		send_letter(KIND_SEARCH, 5'd1, 1'b1);
		// letter past the alphabet fails the insert; the rest is consumed
		send_letter(KIND_INSERT, 5'd1, 1'b0);
		send_letter(KIND_INSERT, 5'd26, 1'b0);
		send_letter(KIND_INSERT, 5'd2, 1'b1);
		// node for "b" was kept but left unmarked
		send_letter(KIND_SEARCH, 5'd1, 1'b1);
		// all-ones letter on both kinds
		send_letter(KIND_SEARCH, 5'd31, 1'b1);
		send_letter(KIND_INSERT, 5'd31, 1'b1);
		// marking an existing inner node, then finding it
		send_letter(KIND_INSERT, 5'd25, 1'b0);
		send_letter(KIND_INSERT, 5'd0, 1'b1);
		send_letter(KIND_SEARCH, 5'd25, 1'b0);
		send_letter(KIND_SEARCH, 5'd0, 1'b1);

		// Random words. The long hold-off starts a quarter in; a stretch
		// in the middle runs with no idling at all.
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start >= RANDOM_ITEMS / 4)
				hold_req = 1'b1;
			quiet = (items_sent - start >= RANDOM_ITEMS / 2) &&
				(items_sent - start < RANDOM_ITEMS * 4 / 5);
			random_word();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain, then give stray answers a chance to show up.
		@(posedge clk);
		while (answers_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && answers_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/twis_pkg.sv
src/twis_ram.sv
src/twis_dp.sv
src/twis_ctrl.sv
src/trie_word_insert_search.sv
verif/trie_word_checker.sv
verif/tb_trie_word_insert_search.sv
